// ===== hw/rtl/flhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flhs_pkg
// Shared types and constants for the four-player link hub sequencer.
// ----------------------------------------------------------------------------
package flhs_pkg;

   // Widths of the hub state
   localparam int COUNT_W = 6;
   localparam int LEN_W   = 5;
   localparam int POS_W   = 7;
   localparam int CLK_W   = 11;
   localparam int STORE_DEPTH = 128;

   // Protocol bytes
   localparam logic [7:0] BYTE_PING_HDR = 8'hFE;
   localparam logic [7:0] BYTE_SYNC     = 8'hCC;
   localparam logic [7:0] BYTE_RESTART  = 8'hFF;
   localparam logic [7:0] BYTE_LINK_REQ = 8'h88;
   localparam logic [7:0] BYTE_SYNC_REQ = 8'hAA;

   localparam logic [7:0]       LINK_STATUS_RESET = 8'h01;
   localparam logic [7:0]       LINK_ID_MASK      = 8'h07;
   localparam logic [CLK_W-1:0] CLOCK_BASE        = 11'd512;

   typedef enum logic [1:0] {
      PH_PING    = 2'd0,
      PH_SYNC    = 2'd1,
      PH_DATA    = 2'd2,
      PH_RESTART = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_CALC   = 2'd1,
      ST_WRITE  = 2'd2,
      ST_FINISH = 2'd3
   } ctrl_state_type;

   typedef struct packed {
      logic       master_internal_clock;
      logic [7:0] p1_byte;
      logic [7:0] p2_byte;
      logic [7:0] p3_byte;
      logic [7:0] p4_byte;
   } hub_req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic [CLK_W-1:0] link_clock;
      logic [1:0]       phase;
   } hub_rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       step;
      logic       wr_en;
      logic [1:0] wr_lane;
      logic       out_load;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic no_result;
      logic wr_needed;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/flhs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flhs_ctrl
// Sequencer: accept, step, capture writes to the packet store, hand off.
// ----------------------------------------------------------------------------
module flhs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire flhs_pkg::status_type st,
   output flhs_pkg::cmd_type         cmd
);

   flhs_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0]               lane_ff, lane_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flhs_pkg::ST_IDLE;
         lane_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      lane_in     = lane_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.wr_lane = lane_ff;
      unique case (state_ff)
         flhs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = flhs_pkg::ST_CALC;
            end
         end
         flhs_pkg::ST_CALC: begin
            cmd.step = 1'b1;
            priority if (st.no_result) begin
               state_in = flhs_pkg::ST_IDLE;
            end else if (st.wr_needed) begin
               // lane 0 goes in with the step itself
               lane_in  = 2'd1;
               state_in = flhs_pkg::ST_WRITE;
            end else begin
               state_in = flhs_pkg::ST_FINISH;
            end
         end
         flhs_pkg::ST_WRITE: begin
            cmd.wr_en = 1'b1;
            lane_in   = lane_ff + 2'd1;
            if (lane_ff == 2'd3) begin
               state_in = flhs_pkg::ST_FINISH;
            end
         end
         flhs_pkg::ST_FINISH: begin
            if (!st.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = flhs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = flhs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/flhs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flhs_datapath
// Hub state, phase step logic, packet store and result register.
// ----------------------------------------------------------------------------
module flhs_datapath #(
   parameter int MAX_PACKET_SIZE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire flhs_pkg::hub_req_type req_data,
   input  wire flhs_pkg::cmd_type     cmd,
   output flhs_pkg::status_type       st,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output flhs_pkg::hub_rsp_type      rsp_data
);

   localparam int CW = flhs_pkg::COUNT_W;
   localparam int LW = flhs_pkg::LEN_W;
   localparam int PW = flhs_pkg::POS_W;
   localparam int KW = flhs_pkg::CLK_W;

   flhs_pkg::hub_req_type req_ff;

   flhs_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    link_status_ff, link_status_in;
   logic [LW-1:0] packet_len_ff, packet_len_in;
   logic [KW-1:0] clock_latch_ff, clock_latch_in;
   logic          sync_pending_ff, sync_pending_in;
   logic          restart_pending_ff, restart_pending_in;
   logic [PW-1:0] replay_ff, replay_in;
   logic          idle_ff, idle_in;
   logic [KW-1:0] link_clock_ff, link_clock_in;

   // per-step scratch
   flhs_pkg::phase_type ph;
   logic          sp, rp;
   logic [7:0]    lstat;
   logic [CW-1:0] nc;
   logic [PW-1:0] len4, bp, pos_inc;
   logic [PW:0]   buflen, tsum, tmod;
   logic [PW:0]   cinc;
   logic          step_write;
   logic [LW-1:0] len_sat;
   logic [KW-1:0] clock_calc;

   // step -> write / finish hand-off
   logic [PW-1:0] t_ff, t_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    ob_ff, ob_in;
   logic          use_mem_ff, use_mem_in;

   // packet store, cleared through valid bits
   logic [7:0]                      mem [flhs_pkg::STORE_DEPTH];
   logic [flhs_pkg::STORE_DEPTH-1:0] vld_ff;
   logic [7:0]                      rd_data_ff;
   logic                            rd_vld_ff;
   logic                            clear_store;
   logic                            mem_we;
   logic [PW-1:0]                   mem_wa, lane_off;
   logic [7:0]                      mem_wd;

   flhs_pkg::hub_rsp_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign len4       = PW'({packet_len_ff, 2'b00});
   assign buflen     = (PW+1)'({packet_len_ff, 3'b000});
   assign len_sat    = (req_ff.p1_byte == 8'd0) ? LW'(1) :
                       (req_ff.p1_byte > 8'(MAX_PACKET_SIZE)) ? LW'(MAX_PACKET_SIZE) :
                       req_ff.p1_byte[LW-1:0];
   // 6 * p1 + base
   assign clock_calc = KW'({req_ff.p1_byte, 2'b00}) + KW'({req_ff.p1_byte, 1'b0})
                       + flhs_pkg::CLOCK_BASE;

   always_comb begin
      phase_in           = phase_ff;
      count_in           = count_ff;
      link_status_in     = link_status_ff;
      packet_len_in      = packet_len_ff;
      clock_latch_in     = clock_latch_ff;
      sync_pending_in    = sync_pending_ff;
      restart_pending_in = restart_pending_ff;
      replay_in          = replay_ff;
      idle_in            = idle_ff;
      link_clock_in      = link_clock_ff;
      t_in               = t_ff;
      len_in             = len_ff;
      ob_in              = ob_ff;
      use_mem_in         = use_mem_ff;
      clear_store        = 1'b0;
      step_write         = 1'b0;
      ph                 = phase_ff;
      sp                 = sync_pending_ff;
      rp                 = restart_pending_ff;
      lstat              = link_status_ff;
      nc                 = count_ff;
      bp                 = (replay_ff >= len4) ? replay_ff - len4 : replay_ff;
      tsum               = (PW+1)'(replay_ff) + (PW+1)'(len4) - (PW+1)'(1);
      tmod               = (tsum >= buflen) ? tsum - buflen : tsum;
      cinc               = (PW+1)'(count_ff) + (PW+1)'(1);
      pos_inc            = ((PW+1)'(replay_ff) + (PW+1)'(1) == buflen) ? '0 :
                           replay_ff + PW'(1);

      if (cmd.step) begin
         if (req_ff.master_internal_clock) begin
            idle_in = 1'b1;
         end else begin
            priority if (!idle_ff && phase_ff == flhs_pkg::PH_PING &&
                         req_ff.p1_byte == flhs_pkg::BYTE_SYNC_REQ && !sync_pending_ff) begin
               sp = 1'b1;
            end else if (idle_ff || phase_ff == flhs_pkg::PH_PING) begin
               ph      = flhs_pkg::PH_PING;
               idle_in = 1'b0;
            end else if (phase_ff == flhs_pkg::PH_DATA &&
                         req_ff.p1_byte == flhs_pkg::BYTE_RESTART && !restart_pending_ff) begin
               rp = 1'b1;
            end

            use_mem_in = 1'b0;
            unique case (ph)
               flhs_pkg::PH_PING: begin
                  if (count_ff == CW'(1) || count_ff == CW'(2)) begin
                     lstat[4] = (req_ff.p1_byte == flhs_pkg::BYTE_LINK_REQ) || sp;
                     lstat[5] = (req_ff.p2_byte == flhs_pkg::BYTE_LINK_REQ);
                     lstat[6] = (req_ff.p3_byte == flhs_pkg::BYTE_LINK_REQ);
                     lstat[7] = (req_ff.p4_byte == flhs_pkg::BYTE_LINK_REQ);
                  end
                  ob_in = (count_ff == '0) ? flhs_pkg::BYTE_PING_HDR : lstat;
                  // 4-byte packet, count wraps at 2 bits
                  nc    = {{(CW-2){1'b0}}, count_ff[1:0] + 2'd1};
                  if (nc == CW'(1) && !sp) begin
                     packet_len_in = len_sat;
                  end
                  if (nc == '0 && !sp) begin
                     clock_latch_in = clock_calc;
                  end
                  if (nc == '0 && sp) begin
                     sp            = 1'b0;
                     ph            = flhs_pkg::PH_SYNC;
                     link_clock_in = clock_latch_ff;
                  end
               end
               flhs_pkg::PH_SYNC: begin
                  ob_in = flhs_pkg::BYTE_SYNC;
                  nc    = {{(CW-2){1'b0}}, count_ff[1:0] + 2'd1};
                  if (nc == '0) begin
                     ph          = flhs_pkg::PH_DATA;
                     replay_in   = '0;
                     clear_store = 1'b1;
                  end
               end
               flhs_pkg::PH_DATA: begin
                  use_mem_in = 1'b1;
                  step_write = (bp != '0) && (bp <= PW'(packet_len_ff));
                  t_in       = tmod[PW-1:0];
                  len_in     = packet_len_ff;
                  nc         = (cinc == (PW+1)'(len4)) ? '0 : cinc[CW-1:0];
                  replay_in  = pos_inc;
                  if (nc == '0 && rp) begin
                     rp = 1'b0;
                     ph = flhs_pkg::PH_RESTART;
                  end
               end
               flhs_pkg::PH_RESTART: begin
                  ob_in = flhs_pkg::BYTE_RESTART;
                  nc    = (cinc == (PW+1)'(len4)) ? '0 : cinc[CW-1:0];
                  if (nc == '0) begin
                     ph    = flhs_pkg::PH_PING;
                     lstat = lstat & flhs_pkg::LINK_ID_MASK;
                  end
               end
               default: begin
                  ph = flhs_pkg::PH_PING;
               end
            endcase
            phase_in           = ph;
            count_in           = nc;
            link_status_in     = lstat;
            sync_pending_in    = sp;
            restart_pending_in = rp;
         end
      end
   end

   // store write port: lane 0 with the step, lanes 1..3 from the sequencer
   assign lane_off = PW'(cmd.wr_lane) * PW'(len_ff);
   assign mem_we   = (cmd.step && step_write) || cmd.wr_en;
   assign mem_wa   = cmd.wr_en ? t_ff + lane_off : t_in;

   always_comb begin
      unique case (cmd.wr_en ? cmd.wr_lane : 2'd0)
         2'd0:    mem_wd = req_ff.p1_byte;
         2'd1:    mem_wd = req_ff.p2_byte;
         2'd2:    mem_wd = req_ff.p3_byte;
         default: mem_wd = req_ff.p4_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.step) begin
         rd_data_ff <= mem[replay_ff];
         rd_vld_ff  <= vld_ff[replay_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_store) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_wa] <= 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_in.out_byte   = use_mem_ff ? (rd_vld_ff ? rd_data_ff : 8'd0) : ob_ff;
         rsp_in.link_clock = link_clock_ff;
         rsp_in.phase      = phase_ff;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      t_ff       <= t_in;
      len_ff     <= len_in;
      ob_ff      <= ob_in;
      use_mem_ff <= use_mem_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= flhs_pkg::PH_PING;
         count_ff           <= '0;
         link_status_ff     <= flhs_pkg::LINK_STATUS_RESET;
         packet_len_ff      <= LW'(1);
         clock_latch_ff     <= flhs_pkg::CLOCK_BASE;
         sync_pending_ff    <= 1'b0;
         restart_pending_ff <= 1'b0;
         replay_ff          <= '0;
         idle_ff            <= 1'b0;
         link_clock_ff      <= flhs_pkg::CLOCK_BASE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         count_ff           <= count_in;
         link_status_ff     <= link_status_in;
         packet_len_ff      <= packet_len_in;
         clock_latch_ff     <= clock_latch_in;
         sync_pending_ff    <= sync_pending_in;
         restart_pending_ff <= restart_pending_in;
         replay_ff          <= replay_in;
         idle_ff            <= idle_in;
         link_clock_ff      <= link_clock_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   assign st.no_result = req_ff.master_internal_clock;
   assign st.wr_needed = step_write;
   assign st.out_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/four_player_link_hub_sequencer_top.sv =====
// Flow: IDLE captures a transfer, CALC steps it, FINISH loads its result; a data-phase
//   transfer that captures player bytes passes WRITE first (three extra store writes).
// A new transfer is taken only after the last is loaded; on internal clock there is
//   no result, and the next is taken after the step. The store has one write port.
// A result still waiting in the output register holds the next transfer back from loading.
// Reset: synchronous; hub enters ping, store reads as zero at once via per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_player_link_hub_sequencer_top
// Four-port serial link hub: ping / sync / data / restart sequencing.
// ----------------------------------------------------------------------------
module four_player_link_hub_sequencer_top #(
   parameter int MAX_PACKET_SIZE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // transfer in: one completed byte exchange
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire flhs_pkg::hub_req_type req_data,
   // transfer out: byte broadcast to all ports
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output flhs_pkg::hub_rsp_type      rsp_data
);

   // command / status between sequencer and datapath
   flhs_pkg::cmd_type    cmd;
   flhs_pkg::status_type st;

   // Sequencer: IDLE takes a transfer, CALC runs the phase step (and the
   // first store write), WRITE covers players 2..4, FINISH loads the
   // output register once it is free.
   flhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Datapath: hub state registers, 128-byte packet store, output register.
   flhs_datapath #(
      .MAX_PACKET_SIZE (MAX_PACKET_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // an accepted transfer is stepped in the very next cycle
   a_accept_then_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cmd.step)
      else $error("accepted transfer not stepped");

   // never overwrite a result the consumer has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !st.out_busy)
      else $error("output register overwritten");

   // no new transfer while one is being stepped or written
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.step || cmd.wr_en |-> !req_ready)
      else $error("transfer accepted while busy");
`endif

endmodule
`default_nettype wire
